@@ rtl/esrs_pkg.sv @@
package esrs_pkg;

  // Width of one stored value word.
  localparam int unsigned DATA_W = 64;

  // Default geometry of the store.
  localparam int unsigned DEF_MAX_ROWS      = 1024;
  localparam int unsigned DEF_SLOTS_PER_ROW = 8;
  localparam int unsigned DEF_COL_WIDTH     = 16;

  // Fixed widths of the request fields and of the size registers.
  localparam int unsigned ROW_W      = 10;
  localparam int unsigned COL_W      = 16;
  localparam int unsigned ROWS_REG_W = 11;
  localparam int unsigned COLS_REG_W = 17;

  // Reset values of the size registers.
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 11'd1024;
  localparam logic [COLS_REG_W-1:0] COLS_RESET = 17'd65536;

  // Configuration register indexes.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Request operations.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_MISS    = 2'd1;
  localparam status_t ST_BAD_ROW = 2'd2;
  localparam status_t ST_BAD_COL = 2'd3;

endpackage

@@ rtl/ell_sparse_row_store.sv @@
// Sparse-matrix store in ELLPACK form: every row owns SLOTS_PER_ROW slots, each holding a
// valid mark, a column tag and a 64-bit value. A write request overwrites the slot whose tag
// matches its column, otherwise claims the lowest empty slot, and is refused with status 1
// when the row is full; a read request returns the stored value, or zero with status 1 when
// the column is absent. Rows at or above rows_in_use (or MAX_ROWS) give status 2, columns at
// or above cols_in_use give status 3, and neither changes the store. A request first reads the
// whole row synchronously from the tag and value memories, then compares all slots at once and
// writes the row back. A following request to the same row therefore always reads the updated
// row. After reset the block runs a clearing pass over the tag memory, one row per cycle, and
// accepts no request until all MAX_ROWS rows are cleared; configuration writes are taken
// throughout. Results wait in an output register, so the next request is accepted while a
// result is being taken.
module ell_sparse_row_store #(
  parameter int unsigned MAX_ROWS      = esrs_pkg::DEF_MAX_ROWS,
  parameter int unsigned SLOTS_PER_ROW = esrs_pkg::DEF_SLOTS_PER_ROW,
  parameter int unsigned COL_WIDTH     = esrs_pkg::DEF_COL_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  // Request channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [esrs_pkg::ROW_W-1:0]   row,
  input  logic [esrs_pkg::COL_W-1:0]   col,
  input  logic [esrs_pkg::DATA_W-1:0]  value,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [esrs_pkg::DATA_W-1:0]  read_value,
  output esrs_pkg::status_t            status,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  import esrs_pkg::*;

  // Row address width, and the layout of one tag memory row: per slot a tag with the
  // valid mark above it.
  localparam int unsigned RAW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned META_E = COL_WIDTH + 1;
  localparam int unsigned META_W = SLOTS_PER_ROW * META_E;
  localparam int unsigned VAL_W  = SLOTS_PER_ROW * DATA_W;

  // Control states.
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // Size registers and the configuration port.
  logic [ROWS_REG_W-1:0] rows_in_use;
  logic [COLS_REG_W-1:0] cols_in_use;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ROWS) begin
        rows_in_use <= pwdata[ROWS_REG_W-1:0];
      end else begin
        cols_in_use <= pwdata[COLS_REG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_ROWS) begin
      prdata = 32'(rows_in_use);
    end else begin
      prdata = 32'(cols_in_use);
    end
  end

  // Request acceptance and range checks, done as the request enters.
  logic            accept;
  logic [31:0]     row_wide;
  logic            bad_row;
  logic            bad_col;
  logic [RAW-1:0]  row_addr;

  assign in_stall = !((state == S_IDLE) && (!out_valid || !out_stall));
  assign accept   = in_valid && !in_stall;
  assign row_wide = 32'(row);
  assign row_addr = row_wide[RAW-1:0];
  assign bad_row  = (row_wide >= 32'(rows_in_use)) || (row_wide >= 32'(MAX_ROWS));
  assign bad_col  = 32'(col) >= 32'(cols_in_use);

  // The request held while the row is looked up.
  logic                   lk_op;
  logic [RAW-1:0]         lk_addr;
  logic [COL_WIDTH-1:0]   lk_tag;
  logic [DATA_W-1:0]      lk_value;
  logic                   lk_bad_row;
  logic                   lk_bad_col;

  always_ff @(posedge clk) begin
    if (accept) begin
      lk_op      <= op;
      lk_addr    <= row_addr;
      lk_tag     <= COL_WIDTH'(32'(col));
      lk_value   <= value;
      lk_bad_row <= bad_row;
      lk_bad_col <= bad_col;
    end
  end

  // Clearing pass over the tag memory.
  logic [RAW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Memories: one row of tags and valid marks, one row of values.
  logic [META_W-1:0] meta_mem [MAX_ROWS];
  logic [VAL_W-1:0]  val_mem  [MAX_ROWS];
  logic [META_W-1:0] meta_q;
  logic [VAL_W-1:0]  val_q;

  logic                     meta_we;
  logic [RAW-1:0]           meta_waddr;
  logic [META_W-1:0]        meta_wdata;
  logic [SLOTS_PER_ROW-1:0] val_we;

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (accept) begin
      meta_q <= meta_mem[row_addr];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SLOTS_PER_ROW; s++) begin
      if (val_we[s]) begin
        val_mem[lk_addr][s*DATA_W +: DATA_W] <= lk_value;
      end
    end
    if (accept) begin
      val_q <= val_mem[row_addr];
    end
  end

  // Compare every slot of the row at once.
  logic [SLOTS_PER_ROW-1:0] slot_vld;
  logic [SLOTS_PER_ROW-1:0] match_vec;
  logic [SLOTS_PER_ROW-1:0] empty_vec;
  logic [SLOTS_PER_ROW-1:0] first_empty;
  logic [DATA_W-1:0]        hit_value;
  logic                     hit;
  logic                     in_range;

  always_comb begin
    hit_value = '0;
    for (int s = 0; s < SLOTS_PER_ROW; s++) begin
      slot_vld[s]  = meta_q[s*META_E + COL_WIDTH];
      match_vec[s] = slot_vld[s] && (meta_q[s*META_E +: COL_WIDTH] == lk_tag);
      if (match_vec[s]) begin
        hit_value = hit_value | val_q[s*DATA_W +: DATA_W];
      end
    end
    empty_vec   = ~slot_vld;
    // Lowest empty slot.
    first_empty = empty_vec & (~empty_vec + 1'b1);
  end

  assign hit      = |match_vec;
  assign in_range = !lk_bad_row && !lk_bad_col;

  // Write-back: a hit overwrites the value only; a claim also sets tag and valid mark.
  logic                     look;
  logic                     claim;
  logic [META_W-1:0]        meta_claim;

  assign look  = (state == S_LOOK);
  assign claim = look && in_range && (lk_op == OP_WRITE) && !hit && (|empty_vec);

  always_comb begin
    meta_claim = meta_q;
    for (int s = 0; s < SLOTS_PER_ROW; s++) begin
      if (first_empty[s]) begin
        meta_claim[s*META_E +: META_E] = {1'b1, lk_tag};
      end
    end
  end

  always_comb begin
    if (state == S_CLEAR) begin
      meta_we    = 1'b1;
      meta_waddr = clr_addr;
      meta_wdata = '0;
    end else begin
      meta_we    = claim;
      meta_waddr = lk_addr;
      meta_wdata = meta_claim;
    end
  end

  always_comb begin
    val_we = '0;
    if (look && in_range && (lk_op == OP_WRITE)) begin
      val_we = hit ? match_vec : first_empty;
    end
  end

  // Result of the request under lookup.
  status_t           res_status;
  logic [DATA_W-1:0] res_value;

  always_comb begin
    res_value = '0;
    if (lk_bad_row) begin
      res_status = ST_BAD_ROW;
    end else if (lk_bad_col) begin
      res_status = ST_BAD_COL;
    end else if (lk_op == OP_READ) begin
      res_status = hit ? ST_OK : ST_MISS;
      res_value  = hit_value;
    end else begin
      res_status = (hit || (|empty_vec)) ? ST_OK : ST_MISS;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (look) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (look) begin
      read_value <= res_value;
      status     <= res_status;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == RAW'(MAX_ROWS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  // No request may enter while the tag memory is still being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("request accepted during clearing pass");

  // Column tags within a row are unique, so at most one slot can match.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    look |-> $onehot0(match_vec))
    else $error("several slots match one column");

  // A result only appears after a lookup cycle.
  a_result_after_look: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_LOOK)
    else $error("result without lookup");

  // Only a read hit carries a value.
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (read_value == '0))
    else $error("non-zero value on a failed request");
`endif

endmodule
